// ----- hdl/tlpt_pkg.sv -----
// Shared definitions for the two-level page table engine.
// Holds sizes, field positions, operation codes and the controller/datapath structs.
// No dependencies.
package tlpt_pkg;

  // Fixed table geometry (10/10/12 address split).
  localparam int DIR_ENTRIES     = 1024;
  localparam int TABLE_ENTRIES   = 1024;
  localparam int TABLE_SLOTS_DEF = 8;
  localparam int IDX_W           = 10;
  localparam int OFS_W           = 12;
  localparam int DIR_SHIFT       = 22;
  localparam int TBL_SHIFT       = 12;
  localparam int USER_FLAG_BIT   = 2;

  // Stream payload widths.
  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int FLAGS_W  = 12;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 40;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_MAP       = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNMAP     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;        // latch the request, read its directory entry
    logic cnt_clr;       // restart the sweep counter
    logic cnt_inc;       // advance the sweep counter
    logic dir_clr_wr;    // write an empty directory entry at the sweep index
    logic alloc;         // take the next table slot and write the directory entry
    logic from_dir;      // leaf address uses the slot just read from the directory
    logic leaf_clr_wr;   // zero a leaf entry at the sweep index
    logic leaf_map_wr;   // write the mapping word
    logic leaf_unmap_wr; // zero the addressed leaf entry
    logic leaf_rd;       // read the addressed leaf entry
    logic res_err;       // answer with status no-memory
    logic res_leaf;      // answer with the translation from the leaf word
    logic out_load;      // move the answer into the output register
  } tlpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              dir_present;
    logic              slots_full;
    logic              sweep_done;
    logic              out_free;
  } tlpt_stat_t;

endpackage

// ----- hdl/tlpt_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the directory and the leaf tables; no dependencies.
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share one address; read data appears the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/tlpt_datapath.sv -----
// Datapath of the page table engine: request registers, directory and leaf RAMs,
// slot counter, sweep counter and output register. Uses tlpt_pkg and tlpt_ram.
module tlpt_datapath
  import tlpt_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tlpt_cmd_t           cmd,
  output tlpt_stat_t          stat,
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_W   = SLOT_W + 2;
  localparam int DIR_AW  = $clog2(DIR_ENTRIES);
  localparam int LEAF_D  = TABLE_SLOTS * TABLE_ENTRIES;
  localparam int LEAF_AW = $clog2(LEAF_D);

  // Request fields unpacked from the input stream.
  logic [FUNC_W-1:0]  in_func;
  logic [ADDR_W-1:0]  in_virt;
  logic [ADDR_W-1:0]  in_phys;
  logic [FLAGS_W-1:0] in_flags;

  assign in_func  = s_tdata[FUNC_W-1:0];
  assign in_virt  = s_tdata[FUNC_W +: ADDR_W];
  assign in_phys  = s_tdata[FUNC_W+ADDR_W +: ADDR_W];
  assign in_flags = s_tdata[FUNC_W+2*ADDR_W +: FLAGS_W];

  // Request registers.
  logic [FUNC_W-1:0]  func_q;
  logic [ADDR_W-1:0]  virt_q;
  logic [ADDR_W-1:0]  phys_q;
  logic [FLAGS_W-1:0] flags_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= in_func;
      virt_q  <= in_virt;
      phys_q  <= in_phys;
      flags_q <= in_flags;
    end
  end

  // Sweep counter used for both clearing passes.
  logic [IDX_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // Slot allocator: hands out table slots in order, never returns them.
  logic [CNT_W-1:0]  slots_used;
  logic [SLOT_W-1:0] slot_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (cmd.alloc) begin
      slots_used <= slots_used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      slot_q <= SLOT_W'(slots_used);
    end
  end

  // Directory RAM: entry holds slot, user and present from the top bit down.
  logic              dir_we;
  logic [DIR_AW-1:0] dir_addr;
  logic [DIR_W-1:0]  dir_wdata;
  logic [DIR_W-1:0]  dir_rdata;
  logic [DIR_AW-1:0] didx_q;

  assign didx_q = virt_q[DIR_SHIFT +: DIR_AW];

  always_comb begin
    if (cmd.accept) begin
      dir_addr = in_virt[DIR_SHIFT +: DIR_AW];
    end else if (cmd.dir_clr_wr) begin
      dir_addr = cnt;
    end else begin
      dir_addr = didx_q;
    end
  end

  assign dir_we    = cmd.dir_clr_wr | cmd.alloc;
  assign dir_wdata = cmd.alloc ? {SLOT_W'(slots_used), flags_q[USER_FLAG_BIT], 1'b1}
                               : '0;

  tlpt_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES),
    .AW    (DIR_AW)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  // Leaf RAM addressed by slot and table index.
  logic [SLOT_W-1:0]  eff_slot;
  logic [IDX_W-1:0]   tidx_sel;
  logic [LEAF_AW-1:0] leaf_addr;
  logic               leaf_we;
  logic [ADDR_W-1:0]  leaf_wdata;
  logic [ADDR_W-1:0]  leaf_rdata;

  assign eff_slot  = cmd.from_dir ? dir_rdata[DIR_W-1:2] : slot_q;
  assign tidx_sel  = cmd.leaf_clr_wr ? cnt : virt_q[TBL_SHIFT +: IDX_W];
  assign leaf_addr = LEAF_AW'({eff_slot, tidx_sel});
  assign leaf_we   = cmd.leaf_clr_wr | cmd.leaf_map_wr | cmd.leaf_unmap_wr;

  // The mapping word keeps the frame and flag bits 11 to 1, and forces the present bit in bit 0.
  assign leaf_wdata = cmd.leaf_map_wr
                    ? {phys_q[ADDR_W-1:OFS_W], flags_q[FLAGS_W-1:1], 1'b1}
                    : '0;

  tlpt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LEAF_D),
    .AW    (LEAF_AW)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we & ~cmd.leaf_rd),
    .addr  (leaf_addr),
    .wdata (leaf_wdata),
    .rdata (leaf_rdata)
  );

  // Answer registers, cleared on each new request.
  logic              res_status;
  logic [ADDR_W-1:0] res_phys;
  logic              res_mapped;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status <= 1'b0;
      res_phys   <= '0;
      res_mapped <= 1'b0;
    end else if (cmd.res_err) begin
      res_status <= 1'b1;
    end else if (cmd.res_leaf && leaf_rdata[0]) begin
      res_phys   <= {leaf_rdata[ADDR_W-1:OFS_W], virt_q[OFS_W-1:0]};
      res_mapped <= 1'b1;
    end
  end

  // Output register decouples the result from the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {(M_DATA_W-ADDR_W-2)'(0), res_mapped, res_phys, res_status};
    end
  end

  // Status back to the controller.
  assign stat.func        = func_q;
  assign stat.dir_present = dir_rdata[0];
  assign stat.slots_full  = (slots_used == CNT_W'(TABLE_SLOTS));
  assign stat.sweep_done  = (cnt == {IDX_W{1'b1}});
  assign stat.out_free    = ~m_tvalid | m_tready;

endmodule

// ----- hdl/tlpt_ctrl.sv -----
// Controller state machine of the page table engine.
// Sequences directory clearing, lookups, slot clearing and result hand-off; uses tlpt_pkg.
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  tlpt_stat_t stat,
  output tlpt_cmd_t  cmd
);

  localparam logic [2:0] ST_DCLR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIR  = 3'd2;
  localparam logic [2:0] ST_LCLR = 3'd3;
  localparam logic [2:0] ST_LWR  = 3'd4;
  localparam logic [2:0] ST_LEAF = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DCLR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_DCLR: begin
        cmd.dir_clr_wr = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (stat.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_DIR;
        end
      end
      ST_DIR: begin
        cmd.from_dir = 1'b1;
        state_next   = ST_RESP;
        unique case (stat.func)
          FUNC_MAP: begin
            if (stat.dir_present) begin
              cmd.leaf_map_wr = 1'b1;
            end else if (stat.slots_full) begin
              cmd.res_err = 1'b1;
            end else begin
              cmd.alloc   = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_next  = ST_LCLR;
            end
          end
          FUNC_UNMAP: begin
            cmd.leaf_unmap_wr = stat.dir_present;
          end
          FUNC_TRANSLATE: begin
            if (stat.dir_present) begin
              cmd.leaf_rd = 1'b1;
              state_next  = ST_LEAF;
            end
          end
          default: begin
            state_next = ST_RESP;
          end
        endcase
      end
      ST_LCLR: begin
        cmd.leaf_clr_wr = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (stat.sweep_done) begin
          state_next = ST_LWR;
        end
      end
      ST_LWR: begin
        cmd.leaf_map_wr = 1'b1;
        state_next      = ST_RESP;
      end
      ST_LEAF: begin
        cmd.res_leaf = 1'b1;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/two_level_page_table_engine_core.sv -----
// Two-level page table engine: map, unmap and translate over a 10/10/12 split.
// Each request runs through the directory read, then for a translate that finds a
// directory entry the leaf read, then the response state; a new request is taken
// only once the last result has moved to the output register. Slot allocation adds
// a sweep that clears the new leaf table; a held result stalls the input. Reset:
// synchronous; the directory RAM is then cleared, and no request is taken until that sweep ends.
module two_level_page_table_engine_core
  import tlpt_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata from bit 0: func[1:0], virt_addr[31:0], frame_addr[31:0], flags[11:0], zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata from bit 0: status, phys_result[31:0], mapped, zero pad
  output logic [M_DATA_W-1:0] m_tdata
);

  tlpt_cmd_t  cmd;
  tlpt_stat_t stat;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlpt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- tb/tlpt_checker.sv -----
// Checker for the two-level page table engine: watches both stream channels.
// It predicts each answer from its own copy of the tables and compares it with the DUT.
// Depends on tlpt_pkg for widths, field positions and operation codes.
module tlpt_checker
  import tlpt_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,
  output int                  mismatches,
  output int                  open_reqs,
  output int                  answers
);

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_NO_MEM = 1'b1;
  localparam int   REQ_BITS  = FUNC_W + 2 * ADDR_W + FLAGS_W;

  typedef struct packed {
    logic       present;
    logic       user;
    logic [6:0] slot;
  } dir_entry_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] phys;
    logic              mapped;
  } answer_t;

  // Shadow copy of the engine's tables.
  dir_entry_t  dir_tab [DIR_ENTRIES];
  logic [31:0] leaf_tab [TABLE_SLOTS * TABLE_ENTRIES];
  int unsigned slots_taken;

  answer_t answer_q [$];
  int      bad_count = 0;
  int      answered  = 0;

  task automatic log_fault(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Apply one request to the shadow tables and return the answer it produces.
  function automatic answer_t walk_tables(input logic [S_DATA_W-1:0] d);
    logic [FUNC_W-1:0]  fn;
    logic [ADDR_W-1:0]  va;
    logic [ADDR_W-1:0]  pa;
    logic [FLAGS_W-1:0] fl;
    logic [IDX_W-1:0]   di;
    logic [IDX_W-1:0]   ti;
    dir_entry_t         de;
    logic [31:0]        leaf;
    int unsigned        base;
    answer_t            a;
    int                 k;
    {fl, pa, va, fn} = d[REQ_BITS-1:0];
    di = va[ADDR_W-1:DIR_SHIFT];
    ti = va[DIR_SHIFT-1:TBL_SHIFT];
    de = dir_tab[di];
    a.status = ST_OK;
    a.phys   = '0;
    a.mapped = 1'b0;
    case (fn)
      FUNC_MAP: begin
        if (!de.present && slots_taken >= TABLE_SLOTS) begin
          a.status = ST_NO_MEM;
        end else begin
          // A missing directory entry takes the next slot, whose table starts empty.
          if (!de.present) begin
            base = slots_taken * TABLE_ENTRIES;
            for (k = 0; k < TABLE_ENTRIES; k++) leaf_tab[base + k] = '0;
            de.present = 1'b1;
            de.user    = fl[USER_FLAG_BIT];
            de.slot    = 7'(slots_taken);
            slots_taken++;
            dir_tab[di] = de;
          end
          leaf_tab[de.slot * TABLE_ENTRIES + ti] = {pa[ADDR_W-1:OFS_W], fl} | 32'd1;
        end
      end
      FUNC_UNMAP: begin
        if (de.present) leaf_tab[de.slot * TABLE_ENTRIES + ti] = '0;
      end
      FUNC_TRANSLATE: begin
        if (de.present) begin
          leaf = leaf_tab[de.slot * TABLE_ENTRIES + ti];
          if (leaf[0]) begin
            a.phys   = {leaf[31:OFS_W], va[OFS_W-1:0]};
            a.mapped = 1'b1;
          end
        end
      end
      default: begin
        // The spare code leaves the tables alone and answers all zeros.
      end
    endcase
    return a;
  endfunction

  // Predict on each accepted request, compare on each accepted answer.
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    int      n;
    if (rst) begin
      for (n = 0; n < DIR_ENTRIES; n++) dir_tab[n] = '0;
      slots_taken = 0;
      answer_q.delete();
    end else begin
      if (s_tvalid && s_tready) answer_q.push_back(walk_tables(s_tdata));
      if (m_tvalid && m_tready) begin
        {got.mapped, got.phys, got.status} = m_tdata[ADDR_W+1:0];
        answered++;
        if (answer_q.size() == 0) begin
          log_fault($sformatf("answer %0d with no request pending: status %b phys %h mapped %b",
                              answered, got.status, got.phys, got.mapped));
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status)
            log_fault($sformatf("answer %0d status: expected %b, got %b",
                                answered, want.status, got.status));
          if (got.phys !== want.phys)
            log_fault($sformatf("answer %0d phys_result: expected %h, got %h",
                                answered, want.phys, got.phys));
          if (got.mapped !== want.mapped)
            log_fault($sformatf("answer %0d mapped: expected %b, got %b",
                                answered, want.mapped, got.mapped));
        end
      end
    end
    mismatches <= bad_count;
    open_reqs  <= answer_q.size();
    answers    <= answered;
  end

endmodule

// ----- tb/two_level_page_table_engine_core_tb.sv -----
// Top of the page table engine testbench: clock, reset, request stimulus and answer sink.
// Instantiates the engine and tlpt_checker beside it; needs tlpt_pkg and both modules.
module two_level_page_table_engine_core_tb;
  import tlpt_pkg::*;

  localparam int SLOTS        = TABLE_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_ITEMS   = 200;
  localparam int DRAIN_AT     = 800;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 8000;
  localparam int TAIL_CYCLES  = 40;
  localparam int DIR_POOL     = 12;
  localparam int TBL_POOL     = 16;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // Packed so that func lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [ADDR_W-1:0]  phys;
    logic [ADDR_W-1:0]  virt;
    logic [FUNC_W-1:0]  func;
  } page_req_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [M_DATA_W-1:0] m_tdata;

  int mismatches;
  int open_reqs;
  int answers;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  logic [IDX_W-1:0] dir_pool [DIR_POOL];
  logic [IDX_W-1:0] tbl_pool [TBL_POOL];

  two_level_page_table_engine_core #(.TABLE_SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tlpt_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .open_reqs  (open_reqs),
    .answers    (answers)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Answer sink: random stall bursts, plus one long hold-off to back the engine up.
  initial begin : answer_sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && answers >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic page_req_t make_req(input logic [FUNC_W-1:0] fn,
                                         input logic [ADDR_W-1:0] va,
                                         input logic [ADDR_W-1:0] pa,
                                         input logic [FLAGS_W-1:0] fl);
    page_req_t r;
    r.func  = fn;
    r.virt  = va;
    r.phys  = pa;
    r.flags = fl;
    return r;
  endfunction

  // Most requests land on a few directory and table indexes so that maps,
  // unmaps and translates meet; the rest use fully random addresses.
  function automatic page_req_t random_request();
    page_req_t        r;
    int               roll;
    logic [OFS_W-1:0] ofs;
    roll = $urandom_range(0, 99);
    if (roll < 35)      r.func = FUNC_MAP;
    else if (roll < 75) r.func = FUNC_TRANSLATE;
    else if (roll < 95) r.func = FUNC_UNMAP;
    else                r.func = FUNC_SPARE;
    r.phys  = $urandom();
    r.flags = FLAGS_W'($urandom_range(0, 4095));
    ofs     = OFS_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 99) < ((r.func == FUNC_MAP) ? 3 : 20))
      r.virt = $urandom();
    else
      r.virt = {dir_pool[$urandom_range(0, DIR_POOL - 1)],
                tbl_pool[$urandom_range(0, TBL_POOL - 1)], ofs};
    return r;
  endfunction

  task automatic pause_sender();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Present one request and hold it until the engine takes it.
  task automatic offer(input page_req_t r);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - $bits(page_req_t)){1'b0}}, r};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_answers();
    do @(posedge clk); while (open_reqs != 0);
  endtask

  initial begin : stimulus
    page_req_t plan [$];
    int        k;
    dir_pool[0] = '0;
    dir_pool[1] = '1;
    for (k = 2; k < DIR_POOL; k++) dir_pool[k] = IDX_W'($urandom_range(0, DIR_ENTRIES - 1));
    tbl_pool[0] = '0;
    tbl_pool[1] = '1;
    for (k = 2; k < TBL_POOL; k++) tbl_pool[k] = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: empty tables, the spare code, address extremes,
    // first maps that allocate slots, remap, unmap and a hole in a live table.
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF));
    plan.push_back(make_req(FUNC_UNMAP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
    plan.push_back(make_req(FUNC_SPARE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
    plan.push_back(make_req(FUNC_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF));
    plan.push_back(make_req(FUNC_MAP,       32'h003F_F123, 32'h1234_5678, 12'h004));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h003F_FABC, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_MAP,       32'h0000_0000, 32'hABCD_E000, 12'h0A0));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h0000_0001, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_UNMAP,     32'h0000_0000, 32'h5555_5555, 12'h555));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_UNMAP,     32'h0000_0000, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h0000_1000, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_MAP,       32'h8000_0000, 32'h8000_0000, 12'h800));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h8000_0FFF, 32'hAAAA_AAAA, 12'hAAA));
    plan.push_back(make_req(FUNC_UNMAP,     32'h8000_0000, 32'hFFFF_FFFF, 12'hFFF));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'h8000_0000, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000));
    plan.push_back(make_req(FUNC_SPARE,     32'h0000_0000, 32'h0000_0000, 12'h000));
    foreach (plan[n]) begin
      pause_sender();
      offer(plan[n]);
    end

    // Random requests; midway the sender waits for every answer to come back.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        drain_answers();
      end
      if (k >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      pause_sender();
      offer(random_request());
    end
    s_tvalid <= 1'b0;

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
